// ===== hdl/arp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants for the ARM REL relocation patcher
// Payload structs, status codes and relocation type numbers.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int DEF_VENEER_SLOTS = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_THUMB_BAD = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [7:0] R_NONE      = 8'd0;
    localparam logic [7:0] R_PC24      = 8'd1;
    localparam logic [7:0] R_ABS32     = 8'd2;
    localparam logic [7:0] R_REL32     = 8'd3;
    localparam logic [7:0] R_THM_CALL  = 8'd10;
    localparam logic [7:0] R_GLOB_DAT  = 8'd21;
    localparam logic [7:0] R_JUMP_SLOT = 8'd22;
    localparam logic [7:0] R_RELATIVE  = 8'd23;
    localparam logic [7:0] R_PLT32     = 8'd27;
    localparam logic [7:0] R_CALL      = 8'd28;
    localparam logic [7:0] R_JUMP24    = 8'd29;
    localparam logic [7:0] R_THM_JUMP24 = 8'd30;
    localparam logic [7:0] R_TARGET1   = 8'd38;
    localparam logic [7:0] R_V4BX      = 8'd40;
    localparam logic [7:0] R_PREL31    = 8'd42;
    localparam logic [7:0] R_MOVW      = 8'd43;
    localparam logic [7:0] R_MOVT      = 8'd44;
    localparam logic [7:0] R_THM_MOVW  = 8'd47;
    localparam logic [7:0] R_THM_MOVT  = 8'd48;

    localparam logic CFG_TABLE_BASE = 1'b0;
    localparam logic CFG_SLOT_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0]  reloc_type;
        logic [31:0] section_base;
        logic [31:0] place_offset;
        logic [31:0] symbol_value;
        logic [31:0] existing_word;
    } t_in;

    typedef struct packed {
        logic [31:0] patched_word;
        logic [1:0]  status;
        logic        veneer_new;
        logic [3:0]  veneer_slot;
    } t_out;

endpackage

// ===== hdl/arp_veneer_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_veneer_scan: veneer slot search
// Walks the slots one per cycle with a single compare unit; claims the first
// free slot or finds the slot already holding the symbol.
// ----------------------------------------------------------------------------
module arp_veneer_scan #(
    parameter int VENEER_SLOTS = arp_pkg::DEF_VENEER_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_sym,
    input  logic [4:0]  i_count,
    output logic        o_done,
    output logic        o_found,
    output logic        o_fresh,
    output logic [$clog2(VENEER_SLOTS+1)-1:0] o_index
);
    import arp_pkg::*;

    localparam int IW = $clog2(VENEER_SLOTS+1);
    localparam int AW = (VENEER_SLOTS > 1) ? $clog2(VENEER_SLOTS) : 1;

    logic [31:0]        r_dest [VENEER_SLOTS];
    logic [VENEER_SLOTS-1:0] r_valid;
    logic               r_busy;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      w_lim;
    logic [AW-1:0]      w_a;
    logic               w_end;
    logic               w_hit;

    always_comb begin
        if ({27'd0, i_count} > VENEER_SLOTS) begin
            w_lim = IW'(VENEER_SLOTS);
        end else begin
            w_lim = IW'(i_count);
        end
    end

    assign w_a   = AW'(r_idx);
    assign w_end = (r_idx >= w_lim);
    assign w_hit = !w_end && (!r_valid[w_a] || r_dest[w_a] == i_sym);

    assign o_done  = r_busy && (w_end || w_hit);
    assign o_found = !w_end;
    assign o_fresh = !w_end && !r_valid[w_a];
    assign o_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= '0;
            r_idx   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (w_end || w_hit) begin
                r_busy <= 1'b0;
                if (w_hit && !r_valid[w_a]) begin
                    r_valid[w_a] <= 1'b1;
                end
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_hit && !r_valid[w_a]) begin
            r_dest[w_a] <= i_sym;
        end
    end

endmodule

// ===== hdl/arm_rel_relocation_patcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_rel_relocation_patcher: ARM ELF REL relocation patcher
// Computes the patched word for one relocation; far ARM branches are routed
// through a veneer table that is searched slot by slot.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// in        in   valid / stall    t_in  (type, base, offset, S, word)
// out       out  valid / stall    t_out (word, status, veneer new/slot)
// cfg       in   valid / ready    index (1 bit), data (32 bits)
//
// Steps per item without a veneer: capture, compute, result. A far ARM
// branch adds a slot scan with its single compare, then a veneer step, or
// a full status result when no slot is found.
// Reset: synchronous, active low; clears veneer valid bits and config.
// Output is held in a register; while a held result is stalled the input
// is stalled too, and a new item is taken in the cycle the result transfers.
// ----------------------------------------------------------------------------
module arm_rel_relocation_patcher #(
    parameter int VENEER_SLOTS = arp_pkg::DEF_VENEER_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  arp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output arp_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import arp_pkg::*;

    localparam int IW = $clog2(VENEER_SLOTS+1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_VEN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_state;
    t_in         r_in;
    logic [31:0] r_p;
    logic [31:0] r_add;
    logic [31:0] r_tbase;
    logic [4:0]  r_cnt;
    logic [3:0]  r_vslot;
    logic        r_vnew;
    logic [31:0] r_voff;
    t_out        r_res;
    logic        r_ovalid;
    t_out        w_res;

    logic        w_accept;
    logic        w_scan_done, w_found, w_fresh;
    logic [IW-1:0] w_sidx;
    logic        w_far;
    logic [31:0] w_t;

    assign o_in_stall  = (r_state != S_IDLE) || (r_ovalid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbase <= '0;
            r_cnt   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TABLE_BASE) begin
                r_tbase <= i_cfg_data;
            end else begin
                r_cnt <= i_cfg_data[4:0];
            end
        end
    end

    arp_veneer_scan #(.VENEER_SLOTS(VENEER_SLOTS)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CALC && w_far),
        .i_sym   (r_in.symbol_value),
        .i_count (r_cnt),
        .o_done  (w_scan_done),
        .o_found (w_found),
        .o_fresh (w_fresh),
        .o_index (w_sidx)
    );

    // ARM branch: near offset, and far flag
    logic [31:0] w_br_t;
    logic        w_is_br;
    always_comb begin
        w_br_t  = r_in.symbol_value - r_p + r_add;
        w_is_br = (r_in.reloc_type == R_PC24) || (r_in.reloc_type == R_PLT32) ||
                  (r_in.reloc_type == R_CALL) || (r_in.reloc_type == R_JUMP24);
        w_far   = w_is_br && (w_br_t[31:25] != 7'h7f) && (w_br_t[31:25] != 7'h00);
    end

    assign w_t = (r_state == S_VEN) ? r_voff : w_br_t;

    always_comb begin
        logic [31:0] w, s, t, a;
        logic [15:0] up, lo;
        logic        sg, j1, j2;
        w  = r_in.existing_word;
        s  = r_in.symbol_value;
        up = w[15:0];
        lo = w[31:16];
        t  = '0;
        a  = '0;
        sg = 1'b0;
        j1 = 1'b0;
        j2 = 1'b0;
        w_res = '{patched_word: w, status: ST_OK, veneer_new: 1'b0, veneer_slot: 4'd0};
        unique case (r_in.reloc_type)
            R_NONE: ;
            R_ABS32, R_TARGET1:     w_res.patched_word = w + s;
            R_GLOB_DAT, R_JUMP_SLOT: w_res.patched_word = s;
            R_RELATIVE: w_res.patched_word = w + r_in.section_base;
            R_REL32:    w_res.patched_word = w + s - r_p;
            R_V4BX:     w_res.patched_word = (w & 32'hf000000f) | 32'h01a0f000;
            R_PREL31: begin
                t = w + s - r_p;
                w_res.patched_word = {w[31], t[30:0]};
            end
            R_PC24, R_PLT32, R_CALL, R_JUMP24: begin
                if (w[27:24] == 4'hB && w_t[1:0] != 2'b00) begin
                    w_res.patched_word = {7'h7d, w_t[1], w_t[25:2]};
                end else begin
                    w_res.patched_word = {w[31:24], w_t[25:2]};
                end
                if (r_state == S_VEN) begin
                    w_res.veneer_new  = r_vnew;
                    w_res.veneer_slot = r_vslot;
                end
            end
            R_MOVW, R_MOVT: begin
                t = {{16{w[19]}}, w[19:16], w[11:0]} + s;
                if (r_in.reloc_type == R_MOVT) begin
                    t = {16'd0, t[31:16]};
                end
                w_res.patched_word = (w & 32'hfff0f000) | {12'd0, t[15:12], 4'd0, t[11:0]};
            end
            R_THM_CALL, R_THM_JUMP24: begin
                sg = up[10];
                a  = {{7{sg}}, sg, ~(lo[13] ^ sg), ~(lo[11] ^ sg), up[9:0], lo[10:0], 1'b0};
                t  = a + s - r_p;
                if (!t[0] || (t + 32'h00ffffff) >= 32'h01ffffff) begin
                    w_res.status = ST_THUMB_BAD;
                end else begin
                    sg = t[24];
                    j1 = sg ^ ~t[23];
                    j2 = sg ^ ~t[22];
                    up = {up[15:11], sg, t[21:12]};
                    lo = {lo[15:14], j1, lo[12], j2, t[11:1]};
                    w_res.patched_word = {lo, up};
                end
            end
            R_THM_MOVW, R_THM_MOVT: begin
                t = {{16{up[3]}}, up[3:0], up[10], lo[14:12], lo[7:0]} + s;
                if (r_in.reloc_type == R_THM_MOVT) begin
                    t = {16'd0, t[31:16]};
                end
                up = (up & 16'hfbf0) | {5'd0, t[11], 6'd0, t[15:12]};
                lo = (lo & 16'h8f00) | {1'b0, t[10:8], 4'd0, t[7:0]};
                w_res.patched_word = {lo, up};
            end
            default: w_res.status = ST_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (w_far) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: if (w_scan_done) begin
                    if (w_found) begin
                        r_state <= S_VEN;
                    end else begin
                        r_state <= S_IDLE;
                        r_ovalid <= 1'b1;
                    end
                end
                S_VEN, S_DONE: begin
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_in  <= i_in_data;
            r_p   <= i_in_data.section_base + i_in_data.place_offset;
            r_add <= {{6{i_in_data.existing_word[23]}}, i_in_data.existing_word[23:0], 2'b00};
        end
        if (r_state == S_SCAN && w_scan_done) begin
            r_vslot <= 4'(w_sidx);
            r_vnew  <= w_fresh;
            r_voff  <= r_tbase + {{(32-IW-3){1'b0}}, w_sidx, 3'b000} - r_p + r_add;
            if (!w_found) begin
                r_res <= '{patched_word: r_in.existing_word, status: ST_FULL,
                           veneer_new: 1'b0, veneer_slot: 4'd0};
            end
        end
        if (r_state == S_VEN || r_state == S_DONE) begin
            r_res <= w_res;
        end
    end

endmodule
